/* design/lfsr_word_generator_assert.svh */
// assertion macros for the lfsr word generator
// expects signals named clk and rst_n in the including module
`ifndef LFSR_WORD_GENERATOR_ASSERT_SVH
`define LFSR_WORD_GENERATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LWG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define LWG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/lwg_pkg.sv */
// package for the lfsr word generator: mode codes, tap masks and the
// gf(2) transfer matrices built at elaboration; no dependencies
`timescale 1ns / 1ps

package lwg_pkg;

  localparam int unsigned STATE_W = 64;

  typedef enum logic [1:0] {
    MODE_W16 = 2'd0,
    MODE_W32 = 2'd1,
    MODE_W64 = 2'd2
  } width_mode_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_GEN  = 1'b1
  } opcode_t;

  localparam width_mode_t MODE_RESET = MODE_W32;

  localparam int unsigned W16 = 16;
  localparam int unsigned W32 = 32;
  localparam int unsigned W64 = 64;

  // feedback positions
  localparam int unsigned FB_POS_16 = 15;
  localparam int unsigned FB_POS_32 = 31;
  localparam int unsigned FB_POS_64 = 58;

  // clocks in 64-bit mode until bits above the feedback bit have drained
  localparam int unsigned DRAIN_STEPS = STATE_W - 1 - FB_POS_64;

  localparam logic [STATE_W-1:0] TAPS_16 = 64'h0000_0000_0000_8017;
  localparam logic [STATE_W-1:0] TAPS_32 = 64'h0000_0000_8000_0057;
  localparam logic [STATE_W-1:0] TAPS_64 = 64'h0400_0000_0000_003D;

  // row i holds the mask of start-state bits whose xor gives bit i
  typedef logic [STATE_W-1:0][STATE_W-1:0] gf2_mat_t;

  // symbolic run of the linear shift register for a number of clocks;
  // returns either the final state map or the collected word map
  function automatic gf2_mat_t build_mat(input int fb_pos, input logic [STATE_W-1:0] taps,
                                         input int steps, input bit want_word);
    gf2_mat_t st;
    gf2_mat_t wd;
    logic [STATE_W-1:0] fb;
    for (int i = 0; i < STATE_W; i++) begin
      st[i] = '0;
      st[i][i] = 1'b1;
    end
    wd = '0;
    for (int k = 0; k < steps; k++) begin
      fb = '0;
      for (int j = 0; j < STATE_W; j++) begin
        if (taps[j]) begin
          fb = fb ^ st[j];
        end
      end
      for (int i = 0; i < STATE_W; i++) begin
        if (i < fb_pos) begin
          st[i] = st[i+1];
        end else if (i > fb_pos) begin
          st[i] = '0;
        end
      end
      st[fb_pos] = fb;
      wd[steps-1-k] = st[0];
    end
    return want_word ? wd : st;
  endfunction

  // matrix times vector over gf(2): one parity per output bit
  function automatic logic [STATE_W-1:0] gf2_apply(input gf2_mat_t m,
                                                   input logic [STATE_W-1:0] v);
    logic [STATE_W-1:0] res;
    for (int i = 0; i < STATE_W; i++) begin
      res[i] = ^(m[i] & v);
    end
    return res;
  endfunction

  localparam gf2_mat_t NS_16 = build_mat(FB_POS_16, TAPS_16, W16, 1'b0);
  localparam gf2_mat_t WD_16 = build_mat(FB_POS_16, TAPS_16, W16, 1'b1);
  localparam gf2_mat_t NS_32 = build_mat(FB_POS_32, TAPS_32, W32, 1'b0);
  localparam gf2_mat_t WD_32 = build_mat(FB_POS_32, TAPS_32, W32, 1'b1);
  localparam gf2_mat_t NS_64 = build_mat(FB_POS_64, TAPS_64, W64 - DRAIN_STEPS, 1'b0);
  localparam gf2_mat_t WD_64 = build_mat(FB_POS_64, TAPS_64, W64 - DRAIN_STEPS, 1'b1);

endpackage

/* design/lfsr_word_generator.sv */
// lfsr word generator: one shift register run at 16, 32 or 64 bits
// input channel in_valid/in_ready carries in_opcode and in_seed_value;
//   a load transaction writes the register, truncated to the width, no result
//   a generate transaction clocks the register once per word bit and returns
//   the collected bits (first bit msb) on out_valid/out_ready as out_random_word
// cfg_we/cfg_wdata write the width mode (0: 16, 1: 32, 2 or 3: 64 bits);
//   write it only while no transaction is in flight
// latency: a generate result is valid the cycle after it is accepted
// throughput: one transaction per cycle; all clocks of a word are folded into
//   precomputed gf(2) matrices, plus five explicit clocks in 64-bit mode
//   while the bits above the feedback tap drain, all in one cycle
// stall: the result register holds until taken; in_ready stays high while
//   the result register is empty or is being taken this cycle
// reset (rst_n low, synchronous): register = 1, mode = 32 bits, no result
`timescale 1ns / 1ps

module lfsr_word_generator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_opcode,
  input  logic [lwg_pkg::STATE_W-1:0] in_seed_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lwg_pkg::STATE_W-1:0] out_random_word
);
  import lwg_pkg::*;

  // registers
  width_mode_t          mode_r, mode_nxt;
  logic [STATE_W-1:0]   state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [STATE_W-1:0]   word_r, word_nxt;

  // datapath
  logic                 in_fire;
  logic [STATE_W-1:0]   width_mask;
  logic [STATE_W-1:0]   state_masked;
  logic [STATE_W-1:0]   start_state;
  logic [STATE_W-1:0]   drained;
  logic [DRAIN_STEPS-1:0] drain_bits;
  logic                 drain_fb;
  logic [STATE_W-1:0]   gen_state;
  logic [STATE_W-1:0]   gen_word;

  assign in_ready        = !out_valid_r || out_ready;
  assign in_fire         = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_random_word = word_r;

  // width mask; unused code 3 runs as 64-bit
  always_comb begin
    case (mode_r)
      MODE_W16: width_mask = {{(STATE_W-W16){1'b0}}, {W16{1'b1}}};
      MODE_W32: width_mask = {{(STATE_W-W32){1'b0}}, {W32{1'b1}}};
      default:  width_mask = {STATE_W{1'b1}};
    endcase
  end

  // truncate to width, then force an all-zero register to one
  assign state_masked = state_r & width_mask;
  assign start_state  = (state_masked == '0) ? STATE_W'(1) : state_masked;

  // 64-bit mode: feedback is ored in at the tap, so the clocks that still see
  // bits above it are run explicitly; after them the register is linear
  always_comb begin
    drained    = start_state;
    drain_bits = '0;
    drain_fb   = 1'b0;
    for (int k = 0; k < DRAIN_STEPS; k++) begin
      drain_fb   = ^(drained & TAPS_64);
      drained    = (drained >> 1) | (STATE_W'(drain_fb) << FB_POS_64);
      drain_bits = {drain_bits[DRAIN_STEPS-2:0], drained[0]};
    end
  end

  // remaining clocks through the elaboration-time transfer matrices
  always_comb begin
    case (mode_r)
      MODE_W16: begin
        gen_state = gf2_apply(NS_16, start_state);
        gen_word  = gf2_apply(WD_16, start_state);
      end
      MODE_W32: begin
        gen_state = gf2_apply(NS_32, start_state);
        gen_word  = gf2_apply(WD_32, start_state);
      end
      default: begin
        gen_state = gf2_apply(NS_64, drained);
        gen_word  = (STATE_W'(drain_bits) << (W64 - DRAIN_STEPS))
                  | gf2_apply(WD_64, drained);
      end
    endcase
  end

  // next-state logic
  always_comb begin
    mode_nxt      = mode_r;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    word_nxt      = word_r;
    if (cfg_we) begin
      mode_nxt = width_mode_t'(cfg_wdata);
    end
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      if (in_opcode == OP_LOAD) begin
        state_nxt = in_seed_value & width_mask;
      end else begin
        state_nxt     = gen_state;
        word_nxt      = gen_word;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_RESET;
      state_r     <= STATE_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    word_r <= word_nxt;
  end

`include "lfsr_word_generator_assert.svh"

  // a generate always leaves a result behind
  `LWG_ASSERT_NEXT(a_gen_gives_result, in_fire && (in_opcode == OP_GEN), out_valid, "generate lost its result")

  // a load never leaves a result behind
  `LWG_ASSERT_NEXT(a_load_no_result, in_fire && (in_opcode == OP_LOAD), !out_valid, "load produced a result")

  // a generate never leaves the register at zero
  `LWG_ASSERT_NEXT(a_gen_nonzero, in_fire && (in_opcode == OP_GEN), state_r != '0, "register stuck at zero")

  // a load in a narrow mode keeps the upper half clear
  `LWG_ASSERT_NEXT(a_load_trunc, in_fire && (in_opcode == OP_LOAD) && !mode_r[1] && !cfg_we, state_r[STATE_W-1:W32] == '0, "load not truncated")

endmodule

/* dv/tb_lfsr_word_generator.sv */
// testbench for lfsr_word_generator: directed rows, then random load and
// generate transactions under three stall patterns and all width modes
// depends on lwg_pkg and the lfsr_word_generator rtl
`timescale 1ns / 1ps

module tb_lfsr_word_generator;
  import lwg_pkg::*;

  // mode 3 is not a package code, it aliases the 64-bit width
  localparam logic [1:0] MODE_W64_ALT = 2'd3;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 4;       // result is valid the cycle after acceptance
  localparam int CYCLE_LIMIT   = 200000;  // watchdog limit for the whole run
  localparam int SEG_ITEMS     = 140;     // transactions per width-mode segment
  localparam int N_DIRECTED    = 29;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [1:0]          cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic                in_opcode;
  logic [STATE_W-1:0]  in_seed_value;
  logic                out_valid;
  logic                out_ready;
  logic [STATE_W-1:0]  out_random_word;

  lfsr_word_generator u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_seed_value   (in_seed_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_random_word (out_random_word)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // shadow copy of the generator: register contents and width mode
  // ---------------------------------------------------------------------------
  logic [STATE_W-1:0] shadow_state;
  logic [1:0]         shadow_mode;
  logic [STATE_W-1:0] expected_words [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;
  int words_checked = 0;
  int loads_sent    = 0;
  int gens_sent     = 0;
  int mode_writes   = 0;
  int cycle_count   = 0;

  // mode bit 1 wins, so mode 3 runs as 64 bits
  function automatic logic [STATE_W-1:0] width_keep_mask(input logic [1:0] mode);
    if (mode[1]) return '1;
    if (mode[0]) return 64'h0000_0000_FFFF_FFFF;
    return 64'h0000_0000_0000_FFFF;
  endfunction

  // runs the register one word forward and returns the collected bits
  function automatic logic [STATE_W-1:0] lfsr_next_word();
    logic [STATE_W-1:0] keep;
    logic [STATE_W-1:0] s;
    logic [STATE_W-1:0] word;
    logic               fb;
    int                 nbits;
    keep  = width_keep_mask(shadow_mode);
    nbits = shadow_mode[1] ? W64 : (shadow_mode[0] ? W32 : W16);
    s     = shadow_state & keep;
    // an all-zero register would lock up, it restarts from one
    if (s == '0) s = 64'd1;
    word = '0;
    for (int k = 0; k < nbits; k++) begin
      if (nbits == W64) begin
        fb = s[58] ^ s[5] ^ s[4] ^ s[3] ^ s[2] ^ s[0];
        s = s >> 1;
        // feedback is ored in, bits 59..63 keep draining down
        s[FB_POS_64] = s[FB_POS_64] | fb;
      end else if (nbits == W32) begin
        fb = s[31] ^ s[6] ^ s[4] ^ s[2] ^ s[1] ^ s[0];
        s = s >> 1;
        s[FB_POS_32] = fb;
      end else begin
        fb = s[15] ^ s[4] ^ s[2] ^ s[1] ^ s[0];
        s = s >> 1;
        s[FB_POS_16] = fb;
      end
      // first bit out ends up in the msb of the word
      word = {word[STATE_W-2:0], s[0]};
    end
    shadow_state = s;
    return word & keep;
  endfunction

  task automatic report_mismatch(input string what, input logic [STATE_W-1:0] got,
                                 input logic [STATE_W-1:0] want);
    $display("mismatch at %0t ns: %s, got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // input side: one transaction, with an optional idle stretch in front
  // ---------------------------------------------------------------------------
  task automatic send_transaction(input opcode_t op, input logic [STATE_W-1:0] seed,
                                  input logic has_fixed, input logic [STATE_W-1:0] fixed_word);
    logic [STATE_W-1:0] word;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_seed_value <= seed;
    // ready is settled by the falling edge, the transaction moves at the next rise
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    if (op == OP_LOAD) begin
      shadow_state = seed & width_keep_mask(shadow_mode);
      loads_sent++;
    end else begin
      word = lfsr_next_word();
      expected_words.push_back(has_fixed ? fixed_word : word);
      gens_sent++;
    end
  endtask

  // width mode changes only once every result is out and the pipe is quiet
  task automatic set_width_mode(input logic [1:0] mode);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
    shadow_mode = mode;
    mode_writes++;
  endtask

  function automatic logic [STATE_W-1:0] random_seed();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return 64'($urandom_range(3));
      3:       return {5'($urandom_range(31)), 59'd0};    // only the draining bits
      4:       return 64'd1 << $urandom_range(63);
      5:       return {32'd0, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // directed rows: a width-mode write or one transaction; the word is typed in
  // only where it is obvious (16-bit mode from a register of one: 15 zeros then
  // a one), the rest goes through the shadow model
  // ---------------------------------------------------------------------------
  typedef enum logic {ROW_CFG, ROW_XACT} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    opcode_t            op;
    logic [STATE_W-1:0] value;       // seed, or the mode for a cfg row
    logic               has_fixed;
    logic [STATE_W-1:0] fixed_word;
  } dir_row_t;

  dir_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_XACT, OP_GEN,  64'd0,                   1'b0, 64'd0},  // first word after reset
    '{ROW_XACT, OP_GEN,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},  // seed ignored on generate
    '{ROW_CFG,  OP_LOAD, 64'(MODE_W16),           1'b0, 64'd0},
    '{ROW_XACT, OP_GEN,  64'd0,                   1'b0, 64'd0},  // 32-bit state cut to 16
    '{ROW_XACT, OP_LOAD, 64'd0,                   1'b0, 64'd0},
    '{ROW_XACT, OP_GEN,  64'd0,                   1'b1, 64'h0001}, // zero restarts at one
    '{ROW_XACT, OP_LOAD, 64'hFFFF_FFFF_FFFF_0000, 1'b0, 64'd0},  // truncates to zero
    '{ROW_XACT, OP_GEN,  64'd0,                   1'b1, 64'h0001},
    '{ROW_XACT, OP_LOAD, 64'd1,                   1'b0, 64'd0},
    '{ROW_XACT, OP_GEN,  64'hDEAD_BEEF_0000_FFFF, 1'b1, 64'h0001},
    '{ROW_XACT, OP_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
    '{ROW_XACT, OP_GEN,  64'd0,                   1'b0, 64'd0},
    '{ROW_CFG,  OP_LOAD, 64'(MODE_W64),           1'b0, 64'd0},
    '{ROW_XACT, OP_GEN,  64'd0,                   1'b0, 64'd0},  // 16-bit state run at 64
    '{ROW_XACT, OP_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
    '{ROW_XACT, OP_GEN,  64'd0,                   1'b0, 64'd0},  // top bits drain
    '{ROW_XACT, OP_LOAD, 64'd0,                   1'b0, 64'd0},
    '{ROW_XACT, OP_GEN,  64'd0,                   1'b0, 64'd0},
    '{ROW_CFG,  OP_LOAD, 64'(MODE_W64_ALT),       1'b0, 64'd0},  // unused mode code
    '{ROW_XACT, OP_LOAD, 64'hF800_0000_0000_0000, 1'b0, 64'd0},
    '{ROW_XACT, OP_GEN,  64'd0,                   1'b0, 64'd0},
    '{ROW_XACT, OP_LOAD, 64'h8000_0000_0000_0001, 1'b0, 64'd0},
    '{ROW_XACT, OP_GEN,  64'd0,                   1'b0, 64'd0},
    '{ROW_CFG,  OP_LOAD, 64'(MODE_W32),           1'b0, 64'd0},
    '{ROW_XACT, OP_GEN,  64'd0,                   1'b0, 64'd0},  // 64-bit state cut to 32
    '{ROW_XACT, OP_LOAD, 64'hFFFF_FFFF_0000_0000, 1'b0, 64'd0},
    '{ROW_XACT, OP_GEN,  64'd0,                   1'b0, 64'd0},
    '{ROW_XACT, OP_LOAD, 64'h0000_0000_FFFF_FFFF, 1'b0, 64'd0},
    '{ROW_XACT, OP_GEN,  64'd0,                   1'b0, 64'd0}
  };

  // ---------------------------------------------------------------------------
  // result side: random stalls, checked on the falling edge where the
  // handshake that completes at the next rise is already stable
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result with nothing pending", out_random_word, '0);
      end else begin
        if (out_random_word !== expected_words[0]) begin
          report_mismatch("random_word", out_random_word, expected_words[0]);
        end
        void'(expected_words.pop_front());
        words_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_words.size());
      $display("** lfsr_word_generator: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [1:0] seg_mode;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= 2'd0;
    in_valid      <= 1'b0;
    in_opcode     <= OP_LOAD;
    in_seed_value <= '0;
    shadow_state  = 64'd1;
    shadow_mode   = MODE_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part with light stalls on the receive side
    recv_idle_pct = 30;
    for (int r = 0; r < N_DIRECTED; r++) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        set_width_mode(directed_rows[r].value[1:0]);
      end else begin
        send_transaction(directed_rows[r].op, directed_rows[r].value,
                         directed_rows[r].has_fixed, directed_rows[r].fixed_word);
      end
    end

    // random part: three stall patterns, each walking all four mode codes
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 30; recv_idle_pct = 50; end
        1:       begin send_idle_pct = 50; recv_idle_pct = 30; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        case ((ph + seg) % 4)
          0:       seg_mode = MODE_W16;
          1:       seg_mode = MODE_W64;
          2:       seg_mode = MODE_W64_ALT;
          default: seg_mode = MODE_W32;
        endcase
        set_width_mode(seg_mode);
        for (int n = 0; n < SEG_ITEMS; n++) begin
          // mostly generates, loads often enough to keep reseeding
          send_transaction(($urandom_range(99) < 30) ? OP_LOAD : OP_GEN, random_seed(),
                           1'b0, '0);
        end
      end
    end

    // drain
    in_valid <= 1'b0;
    recv_idle_pct = 0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (expected_words.size() != 0) begin
      report_mismatch("results left pending", '0, '0);
    end

    $display("covered %0d loads and %0d generates over %0d width-mode writes,",
             loads_sent, gens_sent, mode_writes);
    $display("  %0d words checked under three stall patterns, %0d mismatches",
             words_checked, mismatches);
    if (mismatches == 0) begin
      $display("** lfsr_word_generator: PASSED **");
    end else begin
      $display("** lfsr_word_generator: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/lwg_pkg.sv
design/lfsr_word_generator.sv
dv/tb_lfsr_word_generator.sv
